[design/frmd_pkg.sv]
`default_nettype none
package frmd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQ_W      = 32;
  localparam int SUM_W     = 41;
  localparam int CNT_W     = 11;
  localparam int LEVEL_W   = 11;
  localparam int BAR_W     = 5;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 6;
  localparam int LG_W      = POS_W + FRAC_W;
  localparam int MANT_W    = 31;
  localparam int DIFF_W    = LG_W + 2;
  localparam int PROD_W    = 48;
  localparam int LVL_RAW_W = PROD_W - 32;

  // 160*log10(2) in Q.16, truncated.
  localparam logic signed [DIFF_W-1:0] DB_PER_LOG2_Q16 = 24'sd3156528;
  // 30 in Q.16: the 2^30 full-scale reference of a squared sample.
  localparam logic signed [DIFF_W-1:0] FULL_SCALE_LG = 24'sd1966080;
  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -11'sd960;
  localparam logic [LEVEL_W-1:0] FLOOR_BIAS = 11'd960;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_sixteenths_db;
    logic [BAR_W-1:0]          bar_length;
  } out_beat_t;

  typedef struct packed {
    logic [SUM_W-1:0] square_sum;
    logic [CNT_W-1:0] sample_count;
  } frame_t;

endpackage
`default_nettype wire

[design/frmd_front.sv]
`default_nettype none
module frmd_front #(
  parameter int MAX_FRAME_SAMPLES = 1024
) (
  input  wire               clk,
  input  wire               rst_n,
  input  frmd_pkg::in_beat_t in_data,
  input  wire               in_valid,
  output logic              in_stall,
  output frmd_pkg::frame_t  frm_data,
  output logic              frm_valid,
  input  wire               frm_full
);
  import frmd_pkg::*;

  logic                       s1_valid_r;
  logic [SQ_W-1:0]            sq_r;
  logic                       last_r;
  logic [SUM_W-1:0]           sum_r;
  logic [CNT_W-1:0]           count_r;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [SQ_W-1:0]     sq_prod;
  logic [SUM_W-1:0]           sum_nxt;
  logic [CNT_W-1:0]           count_nxt;
  logic                       frame_end;
  logic                       hold;

  assign smp       = in_data.sample;
  assign sq_prod   = smp * smp;
  assign sum_nxt   = sum_r + {{(SUM_W - SQ_W){1'b0}}, sq_r};
  assign count_nxt = count_r + CNT_W'(1);
  assign frame_end = last_r || (count_nxt == CNT_W'(MAX_FRAME_SAMPLES));

  // A finished frame waits in the accumulate stage until the queue has room.
  assign hold      = s1_valid_r && frame_end && frm_full;
  assign in_stall  = hold;
  assign frm_valid = s1_valid_r && frame_end;
  assign frm_data  = '{square_sum: sum_nxt, sample_count: count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
      count_r    <= '0;
    end else if (!hold) begin
      s1_valid_r <= in_valid;
      if (s1_valid_r) begin
        if (frame_end) begin
          sum_r   <= '0;
          count_r <= '0;
        end else begin
          sum_r   <= sum_nxt;
          count_r <= count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      sq_r   <= SQ_W'(unsigned'(sq_prod));
      last_r <= in_data.last_of_frame;
    end
  end

endmodule
`default_nettype wire

[design/frmd_queue.sv]
`default_nettype none
module frmd_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  frmd_pkg::frame_t wr_data,
  input  wire              wr_valid,
  output logic             full,
  output frmd_pkg::frame_t rd_data,
  output logic             empty,
  input  wire              rd_pop
);
  import frmd_pkg::*;

  frame_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign push    = wr_valid && !full;
  assign pop     = rd_pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[design/frmd_back.sv]
`default_nettype none
module frmd_back (
  input  wire                clk,
  input  wire                rst_n,
  input  frmd_pkg::frame_t   frm_data,
  input  wire                frm_empty,
  output logic               frm_pop,
  output frmd_pkg::out_beat_t out_data,
  output logic               out_valid,
  input  wire                out_stall
);
  import frmd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } state_t;

  state_t                     state_r;
  logic [SUM_W-1:0]           x_r;
  logic [POS_W-1:0]           p_r;
  logic [3:0]                 iter_r;
  logic [MANT_W-1:0]          m_r;
  logic [FRAC_W-1:0]          frac_r;
  logic                       second_r;
  logic                       silent_r;
  logic [LG_W-1:0]            lg_sum_r;
  logic [CNT_W-1:0]           cnt_hold_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       out_valid_r;
  out_beat_t                  out_data_r;

  logic [POS_W-1:0]           sh;
  logic                       top_zero;
  logic [SUM_W-1:0]           x_step;
  logic [POS_W-1:0]           p_step;
  logic [2*MANT_W-1:0]        m_sq;
  logic [MANT_W:0]            m_scaled;
  logic                       frac_bit;
  logic [MANT_W-1:0]          m_next;
  logic [FRAC_W-1:0]          frac_next;
  logic [LG_W-1:0]            lg_new;
  logic signed [DIFF_W-1:0]   diff_calc;
  logic signed [PROD_W-1:0]   prod_calc;
  logic signed [LVL_RAW_W-1:0] lvl_raw;
  logic signed [LEVEL_W-1:0]  lvl_clamp;
  logic [LEVEL_W-1:0]         lvl_biased;
  logic                       out_free;
  logic                       out_load;

  // Normalize by a binary search: steps of 32, 16, 8, 4, 2 and 1 bit.
  always_comb begin
    sh       = POS_W'(32) >> iter_r[2:0];
    top_zero = (x_r & ~({SUM_W{1'b1}} >> sh)) == '0;
    x_step   = top_zero ? (x_r << sh) : x_r;
    p_step   = top_zero ? (p_r - sh) : p_r;
  end

  // One fraction bit per squaring of the Q1.30 mantissa.
  always_comb begin
    m_sq      = m_r * m_r;
    m_scaled  = m_sq[2*MANT_W-1:MANT_W-1];
    frac_bit  = m_scaled[MANT_W];
    m_next    = frac_bit ? m_scaled[MANT_W:1] : m_scaled[MANT_W-1:0];
    frac_next = {frac_r[FRAC_W-2:0], frac_bit};
    lg_new    = {p_r, frac_next};
    diff_calc = $signed({2'b00, lg_sum_r}) - $signed({2'b00, lg_new}) - FULL_SCALE_LG;
    prod_calc = diff_r * DB_PER_LOG2_Q16;
  end

  // The arithmetic right shift by 32 is the floor of the scaled product.
  always_comb begin
    lvl_raw = prod_r[PROD_W-1:32];
    if (silent_r || (lvl_raw < LVL_RAW_W'(LEVEL_FLOOR))) begin
      lvl_clamp = LEVEL_FLOOR;
    end else if (lvl_raw > 0) begin
      lvl_clamp = '0;
    end else begin
      lvl_clamp = lvl_raw[LEVEL_W-1:0];
    end
    lvl_biased = lvl_clamp + FLOOR_BIAS;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == ST_DONE) && out_free;
  assign frm_pop   = (state_r == ST_IDLE) && !frm_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!frm_empty) begin
            x_r        <= frm_data.square_sum;
            cnt_hold_r <= frm_data.sample_count;
            p_r        <= POS_W'(SUM_W - 1);
            iter_r     <= '0;
            second_r   <= 1'b0;
            silent_r   <= (frm_data.square_sum == '0);
            if (frm_data.square_sum == '0) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          x_r <= x_step;
          p_r <= p_step;
          if (iter_r == 4'd5) begin
            m_r     <= x_step[SUM_W-1 -: MANT_W];
            frac_r  <= '0;
            iter_r  <= '0;
            state_r <= ST_SQR;
          end else begin
            iter_r <= iter_r + 4'd1;
          end
        end
        ST_SQR: begin
          m_r    <= m_next;
          frac_r <= frac_next;
          if (iter_r == 4'd15) begin
            iter_r <= '0;
            if (!second_r) begin
              lg_sum_r <= lg_new;
              x_r      <= {{(SUM_W - CNT_W){1'b0}}, cnt_hold_r};
              p_r      <= POS_W'(SUM_W - 1);
              second_r <= 1'b1;
              state_r  <= ST_NORM;
            end else begin
              diff_r  <= diff_calc;
              state_r <= ST_MUL;
            end
          end else begin
            iter_r <= iter_r + 4'd1;
          end
        end
        ST_MUL: begin
          prod_r  <= prod_calc;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r.level_sixteenths_db <= lvl_clamp;
            out_data_r.bar_length          <= lvl_biased[BAR_W+4:5];
            state_r                        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[design/frame_rms_level_meter_db_top.sv]
`default_nettype none
// Samples are taken one beat per clock; the front stalls only when a frame ends while the
// two-entry frame queue is full. The back end takes one frame at a time from the queue:
// 6 normalize steps and 16 squarings for the sum and again for the count, then the
// multiply; a silent frame skips these steps and goes straight to its result.
// Reset (rst_n low, synchronous) clears both accumulators, the queue and the output
// valid flag.
module frame_rms_level_meter_db_top #(
  parameter int MAX_FRAME_SAMPLES = 1024
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  frmd_pkg::in_beat_t  in_data,
  input  wire                 in_valid,
  output logic                in_stall,
  output frmd_pkg::out_beat_t out_data,
  output logic                out_valid,
  input  wire                 out_stall
);
  import frmd_pkg::*;

  // Frame totals handed from the accumulating front to the queue.
  frame_t push_data;
  logic   push_valid;
  logic   q_full;

  // Queue head as seen by the level computation in the back.
  frame_t head_data;
  logic   q_empty;
  logic   q_pop;

  // The front squares each sample in one stage and adds it to the running sum in the next.
  // The last beat of a frame, or the beat that fills a frame to the maximum length,
  // pushes the totals.
  frmd_front #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .frm_data (push_data),
    .frm_valid(push_valid),
    .frm_full (q_full)
  );

  // Two frames of totals can wait here while the back end works on the logarithms.
  frmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_data (push_data),
    .wr_valid(push_valid),
    .full    (q_full),
    .rd_data (head_data),
    .empty   (q_empty),
    .rd_pop  (q_pop)
  );

  // The back end computes the level in decibels and the bar length, and holds the result in
  // an output register, so a stalled consumer does not stop the next frame's computation.
  frmd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm_data (head_data),
    .frm_empty(q_empty),
    .frm_pop  (q_pop),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

endmodule
`default_nettype wire
